// ----- rtl/c8wd_pkg.sv -----
// ----------------------------------------------------------------------------
// c8wd_pkg
// Shared types, constants and the CRC-8 byte function for the word deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package c8wd_pkg;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   localparam logic [1:0] POS_HIGH = 2'd0;
   localparam logic [1:0] POS_LOW  = 2'd1;
   localparam logic [1:0] POS_CRC  = 2'd2;
   localparam logic [1:0] POS_NONE = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
      logic       frame_last;
   } req_type;

   typedef struct packed {
      logic [15:0] word_value;
      logic [7:0]  computed_crc;
      logic        crc_match;
      logic        frame_error;
      logic        frame_end;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

   typedef struct packed {
      logic [1:0] pos;
      logic       err;
   } status_type;

   // CRC-8, poly 0x31, MSB first, one byte
   function automatic logic [7:0] crc8_absorb(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] v;
      v = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/c8wd_if.sv -----
// ----------------------------------------------------------------------------
// c8wd_if
// Valid/ready channels for received bytes and deframed words.
// ----------------------------------------------------------------------------
`default_nettype none

interface c8wd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;
   logic       frame_last;

   modport source (output valid, data_byte, frame_start, frame_last, input ready);
   modport sink   (input valid, data_byte, frame_start, frame_last, output ready);
endinterface

interface c8wd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] word_value;
   logic [7:0]  computed_crc;
   logic        crc_match;
   logic        frame_error;
   logic        frame_end;

   modport source (output valid, word_value, computed_crc, crc_match, frame_error,
                   frame_end, input ready);
   modport sink   (input valid, word_value, computed_crc, crc_match, frame_error,
                   frame_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/c8wd_tracker.sv -----
// ----------------------------------------------------------------------------
// c8wd_tracker
// Byte position, running CRC, word bytes and sticky error; forms one result
// on the CRC byte of each group.
// ----------------------------------------------------------------------------
`default_nettype none

module c8wd_tracker
   import c8wd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire req_type    req,
   output result_type      result,
   output status_type      status
);

   logic [1:0] pos_ff, pos_in;
   logic [7:0] crc_ff, crc_in;
   logic       err_ff, err_in;
   logic [7:0] high_ff, high_in;
   logic [7:0] low_ff, low_in;

   logic [1:0] pos_eff;
   logic [7:0] crc_eff;
   logic       err_eff;
   logic       match;

   always_comb begin
      pos_eff = req.frame_start ? POS_HIGH : pos_ff;
      crc_eff = req.frame_start ? CRC_INIT : crc_ff;
      err_eff = req.frame_start ? 1'b0 : err_ff;
      match   = (req.data_byte == crc_eff);

      pos_in  = pos_ff;
      crc_in  = crc_ff;
      err_in  = err_ff;
      high_in = high_ff;
      low_in  = low_ff;

      result.valid             = 1'b0;
      result.data.word_value   = {high_ff, low_ff};
      result.data.computed_crc = crc_eff;
      result.data.crc_match    = match;
      result.data.frame_error  = err_eff | ~match;
      result.data.frame_end    = req.frame_last;

      if (accept) begin
         unique case (pos_eff)
            POS_LOW: begin
               low_in = req.data_byte;
               crc_in = crc8_absorb(crc_eff, req.data_byte);
               pos_in = POS_CRC;
               err_in = err_eff;
            end
            POS_CRC: begin
               result.valid = 1'b1;
               pos_in = POS_HIGH;
               crc_in = CRC_INIT;
               err_in = err_eff | ~match;
            end
            POS_HIGH, POS_NONE: begin
               high_in = req.data_byte;
               crc_in  = crc8_absorb(CRC_INIT, req.data_byte);
               pos_in  = POS_LOW;
               err_in  = err_eff;
            end
            default: begin
               pos_in = POS_HIGH;
            end
         endcase
         if (req.frame_last) begin
            pos_in = POS_HIGH;
            crc_in = CRC_INIT;
            err_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HIGH;
         crc_ff <= CRC_INIT;
         err_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         err_ff <= err_in;
      end
      high_ff <= high_in;
      low_ff  <= low_in;
   end

   assign status.pos = pos_ff;
   assign status.err = err_ff;

endmodule

`default_nettype wire

// ----- rtl/c8wd_out_reg.sv -----
// ----------------------------------------------------------------------------
// c8wd_out_reg
// Result register: holds one word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module c8wd_out_reg
   import c8wd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire result_type result,
   input  wire logic       out_ready,
   output logic            load_ok,
   output logic            out_valid,
   output rsp_type         out_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   always_comb begin
      load_ok  = ~valid_ff | out_ready;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load_ok) begin
         valid_in = result.valid;
         if (result.valid) begin
            data_in = result.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ----- rtl/crc8_word_deframer.sv -----
// Output: a word is registered and appears on rsp in the cycle after its CRC byte is accepted.
// Throughput: one byte per cycle; the CRC byte network sits between the
// state registers and the result register, and only a held result stalls req.
// Reset: synchronous, active high; clears byte position, running CRC (0xFF),
// the sticky error and the result valid.
// ----------------------------------------------------------------------------
// crc8_word_deframer
// Groups response bytes into 16-bit words with CRC-8 check and frame error.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8_word_deframer
   import c8wd_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   c8wd_req_if.sink    req_bus,
   c8wd_rsp_if.source  rsp_bus
);

   req_type    req;
   result_type result;
   status_type status;
   rsp_type    out_data;
   logic       load_ok;
   logic       accept;

   assign req.data_byte   = req_bus.data_byte;
   assign req.frame_start = req_bus.frame_start;
   assign req.frame_last  = req_bus.frame_last;

   assign req_bus.ready = load_ok;
   assign accept        = req_bus.valid & load_ok;

   c8wd_tracker u_tracker (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req),
      .result (result),
      .status (status)
   );

   c8wd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .out_ready (rsp_bus.ready),
      .load_ok   (load_ok),
      .out_valid (rsp_bus.valid),
      .out_data  (out_data)
   );

   assign rsp_bus.word_value   = out_data.word_value;
   assign rsp_bus.computed_crc = out_data.computed_crc;
   assign rsp_bus.crc_match    = out_data.crc_match;
   assign rsp_bus.frame_error  = out_data.frame_error;
   assign rsp_bus.frame_end    = out_data.frame_end;

   a_pos_legal: assert property (@(posedge clock) disable iff (reset)
      status.pos != POS_NONE)
      else $error("byte position left the group");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req.frame_last |=> status.pos == POS_HIGH && !status.err)
      else $error("frame end did not clear frame state");

   a_mismatch_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.crc_match |-> rsp_bus.frame_error)
      else $error("CRC mismatch without frame error");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |-> !req_bus.ready)
      else $error("byte taken while result held");

endmodule

`default_nettype wire

// ----- verif/c8wd_word_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// c8wd_word_checker
// Watches both channels of the word deframer, tracks group position, running
// CRC-8 and the sticky frame error for every accepted byte, and compares each
// word that leaves the block with the oldest word it expects.
// ----------------------------------------------------------------------------

module c8wd_word_checker
   import c8wd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   c8wd_req_if  req_mon,
   c8wd_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_words,
   output int   words_checked,
   output int   bad_crc_words
);

   rsp_type    expected_words[$];
   logic [1:0] grp_pos;
   logic [7:0] crc_acc;
   logic [7:0] hi_q;
   logic [7:0] lo_q;
   logic       err_flag;
   int         n_fail;
   int         n_words;
   int         n_bad;

   // bitwise MSB-first CRC-8 over one byte
   function automatic logic [7:0] crc_byte_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] r;
      r = crc;
      for (int i = 7; i >= 0; i--) begin
         r = {r[6:0], 1'b0} ^ ((r[7] ^ b[i]) ? CRC_POLY : 8'h00);
      end
      return r;
   endfunction

   task automatic clear_frame_state();
      grp_pos  = POS_HIGH;
      crc_acc  = CRC_INIT;
      err_flag = 1'b0;
   endtask

   task automatic absorb_byte(input logic [7:0] b, input logic s, input logic l);
      rsp_type w;
      logic    ok;
      if (s) begin
         clear_frame_state();
      end
      case (grp_pos)
         POS_LOW: begin
            lo_q    = b;
            crc_acc = crc_byte_step(crc_acc, b);
            grp_pos = POS_CRC;
         end
         POS_CRC: begin
            ok = (b == crc_acc);
            if (!ok) begin
               err_flag = 1'b1;
            end
            w.word_value   = {hi_q, lo_q};
            w.computed_crc = crc_acc;
            w.crc_match    = ok;
            w.frame_error  = err_flag;
            w.frame_end    = l;
            expected_words.push_back(w);
            grp_pos = POS_HIGH;
            crc_acc = CRC_INIT;
         end
         default: begin
            hi_q    = b;
            crc_acc = crc_byte_step(CRC_INIT, b);
            grp_pos = POS_LOW;
         end
      endcase
      if (l) begin
         clear_frame_state();
      end
   endtask

   task automatic check_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         n_fail++;
      end
   endtask

   task automatic compare_word();
      rsp_type w;
      if (expected_words.size() == 0) begin
         $error("word_value: expected none, got 0x%0h", rsp_mon.word_value);
         n_fail++;
      end else begin
         w = expected_words.pop_front();
         check_field("word_value", 32'(w.word_value), 32'(rsp_mon.word_value));
         check_field("computed_crc", 32'(w.computed_crc), 32'(rsp_mon.computed_crc));
         check_field("crc_match", 32'(w.crc_match), 32'(rsp_mon.crc_match));
         check_field("frame_error", 32'(w.frame_error), 32'(rsp_mon.frame_error));
         check_field("frame_end", 32'(w.frame_end), 32'(rsp_mon.frame_end));
         n_words++;
         if (!w.crc_match) begin
            n_bad++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_words.delete();
         clear_frame_state();
         hi_q    = 8'h00;
         lo_q    = 8'h00;
         n_fail  = 0;
         n_words = 0;
         n_bad   = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            compare_word();
         end
         if (req_mon.valid && req_mon.ready) begin
            absorb_byte(req_mon.data_byte, req_mon.frame_start, req_mon.frame_last);
         end
      end
      fail_count    <= n_fail;
      pending_words <= expected_words.size();
      words_checked <= n_words;
      bad_crc_words <= n_bad;
   end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Top of the word deframer bench: drives response bytes as directed cases,
// well-formed frames with random words and CRC faults, and loose noise, with
// random idling on both channels and one long output hold-off; the checker
// beside the block predicts and compares every word.
// ----------------------------------------------------------------------------

module tb;
   import c8wd_pkg::*;

   typedef enum logic [1:0] {
      STAGE_DIRECTED,
      STAGE_PRESSURE,
      STAGE_RANDOM,
      STAGE_QUIET
   } stage_type;

   localparam int RANDOM_BYTES = 500;
   localparam int QUIET_BYTES  = 560;
   localparam int HOLD_CYCLES  = 120;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 200000;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   stage_type stage = STAGE_DIRECTED;
   bit        idle_on = 1'b1;
   int        bytes_sent = 0;
   int        cycle_count = 0;
   int        fail_count;
   int        pending_words;
   int        words_checked;
   int        bad_crc_words;

   c8wd_req_if req_ch ();
   c8wd_rsp_if rsp_ch ();

   crc8_word_deframer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   c8wd_word_checker chk (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .pending_words (pending_words),
      .words_checked (words_checked),
      .bad_crc_words (bad_crc_words)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic logic [7:0] crc_of_word(input logic [15:0] w);
      logic [7:0] r;
      r = CRC_INIT;
      for (int i = 15; i >= 0; i--) begin
         r = {r[6:0], 1'b0} ^ ((r[7] ^ w[i]) ? CRC_POLY : 8'h00);
      end
      return r;
   endfunction

   // called and returns at a falling edge
   task automatic push_byte(input logic [7:0] b, input logic s, input logic l);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 11);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.data_byte   <= b;
      req_ch.frame_start <= s;
      req_ch.frame_last  <= l;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_word(input logic [15:0] w, input logic [7:0] c,
                            input logic s, input logic l);
      push_byte(w[15:8], s, 1'b0);
      push_byte(w[7:0], 1'b0, 1'b0);
      push_byte(c, 1'b0, l);
   endtask

   task automatic send_frame(input int n_words);
      logic [15:0] w;
      logic [7:0]  c;
      bit          with_start;
      bit          with_last;
      with_start = $urandom_range(0, 9) != 0;
      with_last  = $urandom_range(0, 9) != 0;
      for (int i = 0; i < n_words; i++) begin
         case ($urandom_range(0, 7))
            0:       w = 16'h0000;
            1:       w = 16'hFFFF;
            default: w = 16'($urandom);
         endcase
         c = crc_of_word(w);
         if ($urandom_range(0, 6) == 0) begin
            c = c ^ 8'($urandom_range(1, 255));
         end
         send_word(w, c, with_start && i == 0, with_last && i == n_words - 1);
      end
   endtask

   task automatic send_noise(input int n);
      repeat (n) begin
         push_byte(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
      end
   endtask

   // receiver: random stall bursts, one long hold-off while under pressure
   initial begin
      int  n;
      bit  long_done;
      long_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(negedge clock);
      forever begin
         if (stage == STAGE_PRESSURE && !long_done) begin
            long_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 11);
            rsp_ch.ready <= 1'b0;
            repeat (n) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   initial begin
      req_ch.valid       <= 1'b0;
      req_ch.data_byte   <= 8'h00;
      req_ch.frame_start <= 1'b0;
      req_ch.frame_last  <= 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed
      send_word(16'hBEEF, 8'h92, 1'b1, 1'b0);
      send_word(16'h0000, crc_of_word(16'h0000) ^ 8'h01, 1'b0, 1'b0);
      send_word(16'hFFFF, crc_of_word(16'hFFFF), 1'b0, 1'b1);
      send_word(16'h1234, crc_of_word(16'h1234), 1'b0, 1'b0);
      push_byte(8'hAB, 1'b0, 1'b0);
      send_word(16'h5A00, crc_of_word(16'h5A00), 1'b1, 1'b0);
      push_byte(8'h77, 1'b0, 1'b1);
      push_byte(8'h11, 1'b0, 1'b0);
      push_byte(8'h22, 1'b0, 1'b1);
      push_byte(8'h80, 1'b1, 1'b1);
      send_word(16'h00FF, crc_of_word(16'h00FF) ^ 8'hFF, 1'b1, 1'b1);

      // long output hold-off with the input kept busy
      stage   = STAGE_PRESSURE;
      idle_on = 1'b0;
      repeat (8) send_frame(2);

      stage = STAGE_RANDOM;
      while (bytes_sent < RANDOM_BYTES) begin
         idle_on = $urandom_range(0, 3) != 0;
         if ($urandom_range(0, 9) == 0) begin
            send_noise($urandom_range(1, 5));
         end else begin
            send_frame($urandom_range(1, 4));
         end
      end

      stage   = STAGE_QUIET;
      idle_on = 1'b0;
      while (bytes_sent < QUIET_BYTES) begin
         send_frame($urandom_range(1, 4));
      end
      req_ch.valid <= 1'b0;

      while (pending_words != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d bytes in, %0d words checked, %0d of them with a bad CRC",
               bytes_sent, words_checked, bad_crc_words);
      $display("run: directed frame cases, random frames and noise, %0d-cycle output hold",
               HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/c8wd_pkg.sv
rtl/c8wd_if.sv
rtl/c8wd_tracker.sv
rtl/c8wd_out_reg.sv
rtl/crc8_word_deframer.sv
verif/c8wd_word_checker.sv
verif/tb.sv
